// ----- src/ncbm_pkg.sv -----
// Shared types and constants for the cartridge bank mapper with cycle IRQ.
`timescale 1ns / 1ps
`default_nettype none

package ncbm_pkg;

  localparam int unsigned PRG_BANKS_8K_DEFAULT = 64;
  localparam int unsigned CHR_BANKS_1K_DEFAULT = 256;

  typedef enum logic [1:0] {
    ACT_WRITE     = 2'd0,
    ACT_TICK      = 2'd1,
    ACT_CPU_XLATE = 2'd2,
    ACT_PPU_XLATE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REGION_NONE = 2'd0,
    REGION_PRG  = 2'd1,
    REGION_SRAM = 2'd2,
    REGION_CHR  = 2'd3
  } region_e;

  // Register window 0x7EF0-0x7EFF: upper twelve address bits, then offsets.
  localparam logic [11:0] REG_WINDOW     = 12'h7EF;
  localparam logic [3:0]  REG_CHR_FIRST  = 4'd0;
  localparam logic [3:0]  REG_CHR_LAST   = 4'd5;
  localparam logic [3:0]  REG_CTRL       = 4'd6;
  localparam logic [3:0]  REG_KEY_FIRST  = 4'd7;
  localparam logic [3:0]  REG_KEY_LAST   = 4'd9;
  localparam logic [3:0]  REG_PRG_FIRST  = 4'd10;
  localparam logic [3:0]  REG_PRG_LAST   = 4'd12;
  localparam logic [3:0]  REG_IRQ_LATCH  = 4'd13;
  localparam logic [3:0]  REG_IRQ_CTRL   = 4'd14;
  localparam logic [3:0]  REG_IRQ_RELOAD = 4'd15;

  localparam logic [7:0] SRAM_KEY0 = 8'hCA;
  localparam logic [7:0] SRAM_KEY1 = 8'h69;
  localparam logic [7:0] SRAM_KEY2 = 8'h84;

  localparam logic [7:0] PRG_FIXED_BANK = 8'hFF;

  // Control byte bits
  localparam int unsigned CTRL_MIRROR_BIT   = 0;
  localparam int unsigned CTRL_CHR_SWAP_BIT = 1;

  // IRQ control bits
  localparam int unsigned IRQ_COUNT_BIT  = 0;
  localparam int unsigned IRQ_ENABLE_BIT = 1;
  localparam int unsigned IRQ_HOLD_BIT   = 2;

  localparam logic [12:0] IRQ_RELOAD_ZERO_LATCH = 13'd1;
  localparam logic [12:0] IRQ_TICK_ZERO_LATCH   = 13'd17;

  typedef struct packed {
    logic [2:0][7:0] prg;
    logic [5:0][7:0] chr;
    logic [7:0]      ctrl;
    logic [2:0][7:0] key;
  } bank_state_t;

  localparam bank_state_t BANK_STATE_RESET = '{
    prg:  {8'hFE, 8'h01, 8'h00},
    chr:  '0,
    ctrl: 8'h00,
    key:  '0
  };

  typedef struct packed {
    region_e     region;
    logic [18:0] phys_addr;
    logic        access_enabled;
  } xlate_res_t;

endpackage

`default_nettype wire

// ----- src/ncbm_xlate.sv -----
// CPU and PPU address translation onto PRG ROM, save RAM and CHR.
`timescale 1ns / 1ps
`default_nettype none

module ncbm_xlate import ncbm_pkg::*; #(
  parameter int unsigned PRG_BANKS_8K = PRG_BANKS_8K_DEFAULT,
  parameter int unsigned CHR_BANKS_1K = CHR_BANKS_1K_DEFAULT
) (
  input  action_e     action_i,
  input  logic [15:0] address_i,
  input  bank_state_t bank_i,
  input  logic        prg_rev_i,
  output xlate_res_t  res_o
);

  localparam int unsigned CHR_BANKS_2K = CHR_BANKS_1K / 2;

  // Bank wrap tables, filled at elaboration
  logic [5:0] prg_wrap [256];
  logic [6:0] chr2_wrap [128];
  logic [7:0] chr1_wrap [256];

  for (genvar i = 0; i < 256; i++) begin : g_wrap8
    assign prg_wrap[i]  = 6'(i % PRG_BANKS_8K);
    assign chr1_wrap[i] = 8'(i % CHR_BANKS_1K);
  end
  for (genvar i = 0; i < 128; i++) begin : g_wrap7
    assign chr2_wrap[i] = 7'(i % CHR_BANKS_2K);
  end

  logic [1:0]  prg_win;
  logic [7:0]  prg_raw;
  logic [7:0]  prg_idx;
  logic [5:0]  prg_bank;
  logic [12:0] ppu_a;
  logic [7:0]  chr_lo_reg;
  logic [7:0]  chr_hi_reg;
  logic [6:0]  chr_lo_bank;
  logic [7:0]  chr_hi_bank;

  always_comb begin
    prg_win = address_i[14:13];
    prg_raw = (prg_win == 2'd3) ? 8'h00 : bank_i.prg[prg_win];
    if (prg_win == 2'd3) begin
      prg_idx = PRG_FIXED_BANK;
    end else if (prg_rev_i) begin
      prg_idx = {2'b00, prg_raw[0], prg_raw[1], prg_raw[2],
                 prg_raw[3], prg_raw[4], prg_raw[5]};
    end else begin
      prg_idx = {2'b00, prg_raw[7:2]};
    end
    prg_bank = prg_wrap[prg_idx];
  end

  // CHR half swap flips A12 before the bank lookup
  always_comb begin
    ppu_a       = address_i[12:0] ^ {bank_i.ctrl[CTRL_CHR_SWAP_BIT], 12'h000};
    chr_lo_reg  = bank_i.chr[{2'b00, ppu_a[11]}];
    chr_hi_reg  = bank_i.chr[3'd2 + {1'b0, ppu_a[11:10]}];
    chr_lo_bank = chr2_wrap[chr_lo_reg[7:1]];
    chr_hi_bank = chr1_wrap[chr_hi_reg];
  end

  always_comb begin
    res_o = '{region: REGION_NONE, phys_addr: '0, access_enabled: 1'b0};
    case (action_i)
      ACT_CPU_XLATE: begin
        if (address_i[15]) begin
          res_o.region         = REGION_PRG;
          res_o.phys_addr      = {prg_bank, address_i[12:0]};
          res_o.access_enabled = 1'b1;
        end else if (address_i[15:11] == 5'b01100) begin
          res_o.region         = REGION_SRAM;
          res_o.phys_addr      = 19'(address_i[10:0]);
          res_o.access_enabled = (bank_i.key[0] == SRAM_KEY0);
        end else if (address_i[15:11] == 5'b01101) begin
          res_o.region         = REGION_SRAM;
          res_o.phys_addr      = 19'({1'b1, address_i[10:0]});
          res_o.access_enabled = (bank_i.key[1] == SRAM_KEY1);
        end else if (address_i[15:10] == 6'b011100) begin
          res_o.region         = REGION_SRAM;
          res_o.phys_addr      = 19'({3'b100, address_i[9:0]});
          res_o.access_enabled = (bank_i.key[2] == SRAM_KEY2);
        end
      end
      ACT_PPU_XLATE: begin
        if (address_i[15:13] == 3'b000) begin
          res_o.region         = REGION_CHR;
          res_o.access_enabled = 1'b1;
          if (!ppu_a[12]) begin
            res_o.phys_addr = 19'({chr_lo_bank, ppu_a[10:0]});
          end else begin
            res_o.phys_addr = 19'({chr_hi_bank, ppu_a[9:0]});
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/nes_cartridge_bank_mapper_irq.sv -----
// Top level: register file, IRQ counter and registered result stage.
//
//  channel | signals                           | direction | moves
//  --------+-----------------------------------+-----------+---------------------------
//  in      | in_valid_i, in_stall_o            | in        | action, address, data
//  out     | out_valid_o, out_stall_i          | out       | irq, mirroring, translation
//  cfg     | cfg_valid_i, cfg_ready_o          | in        | PRG bit-reversal select
//
// One request per cycle while in_stall_o is low; its result appears on the output register
// in the cycle after it is taken. Register updates, the IRQ counter step and the translation
// lookup all sit in the single stage ahead of that register.
// Reset (rst_ni low, asynchronous) restores the power-up bank values and empties the
// output register. A request is taken while the output register is empty or being
// drained; the input stalls only when a held result is itself stalled.

`timescale 1ns / 1ps
`default_nettype none

module nes_cartridge_bank_mapper_irq import ncbm_pkg::*; #(
  parameter int unsigned PRG_BANKS_8K = PRG_BANKS_8K_DEFAULT,
  parameter int unsigned CHR_BANKS_1K = CHR_BANKS_1K_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        irq_line_o,
  output logic        mirroring_vertical_o,
  output logic [1:0]  region_o,
  output logic [18:0] phys_addr_o,
  output logic        access_enabled_o
);

  logic        prg_rev_q;
  bank_state_t bank_q, bank_d;
  logic [7:0]  irq_latch_q, irq_latch_d;
  logic [7:0]  irq_ctrl_q, irq_ctrl_d;
  logic [12:0] irq_cnt_q, irq_cnt_d;
  logic        irq_q, irq_d;

  logic        out_valid_q;
  logic        res_irq_q;
  logic        res_mirror_q;
  xlate_res_t  res_xl_q;
  xlate_res_t  xl;

  action_e     act;
  logic        accept;
  logic        reg_hit;
  logic [3:0]  reg_idx;
  logic [8:0]  latch_p1;
  logic [8:0]  latch_p2;

  assign act         = action_e'(action_i);
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  assign reg_hit  = (act == ACT_WRITE) && (address_i[15:4] == REG_WINDOW);
  assign reg_idx  = address_i[3:0];
  assign latch_p1 = {1'b0, irq_latch_q} + 9'd1;
  assign latch_p2 = {1'b0, irq_latch_q} + 9'd2;

  always_comb begin
    bank_d      = bank_q;
    irq_latch_d = irq_latch_q;
    irq_ctrl_d  = irq_ctrl_q;
    irq_cnt_d   = irq_cnt_q;
    irq_d       = irq_q;
    if (reg_hit) begin
      case (reg_idx) inside
        [REG_CHR_FIRST:REG_CHR_LAST]: bank_d.chr[3'(reg_idx - REG_CHR_FIRST)] = data_i;
        REG_CTRL:                     bank_d.ctrl = data_i;
        [REG_KEY_FIRST:REG_KEY_LAST]: bank_d.key[2'(reg_idx - REG_KEY_FIRST)] = data_i;
        [REG_PRG_FIRST:REG_PRG_LAST]: bank_d.prg[2'(reg_idx - REG_PRG_FIRST)] = data_i;
        REG_IRQ_LATCH:                irq_latch_d = data_i;
        REG_IRQ_CTRL:                 irq_ctrl_d = data_i;
        REG_IRQ_RELOAD: begin
          irq_cnt_d = (irq_latch_q != 8'h00) ? {latch_p1, 4'h0} : IRQ_RELOAD_ZERO_LATCH;
          irq_d     = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (act == ACT_TICK) begin
      if (irq_ctrl_q[IRQ_COUNT_BIT] && !irq_ctrl_q[IRQ_HOLD_BIT]) begin
        // count down, sticks at zero
        irq_cnt_d = (irq_cnt_q != 13'd0) ? irq_cnt_q - 13'd1 : 13'd0;
      end else begin
        irq_cnt_d = (irq_latch_q != 8'h00) ? {latch_p2, 4'h0} : IRQ_TICK_ZERO_LATCH;
      end
      irq_d = irq_ctrl_q[IRQ_ENABLE_BIT] && (irq_cnt_d == 13'd0);
    end
  end

  ncbm_xlate #(
    .PRG_BANKS_8K (PRG_BANKS_8K),
    .CHR_BANKS_1K (CHR_BANKS_1K)
  ) u_xlate (
    .action_i  (act),
    .address_i (address_i),
    .bank_i    (bank_q),
    .prg_rev_i (prg_rev_q),
    .res_o     (xl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_rev_q   <= 1'b0;
      bank_q      <= BANK_STATE_RESET;
      irq_latch_q <= '0;
      irq_ctrl_q  <= '0;
      irq_cnt_q   <= '0;
      irq_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        prg_rev_q <= cfg_data_i;
      end
      if (accept) begin
        bank_q      <= bank_d;
        irq_latch_q <= irq_latch_d;
        irq_ctrl_q  <= irq_ctrl_d;
        irq_cnt_q   <= irq_cnt_d;
        irq_q       <= irq_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_irq_q    <= irq_d;
      res_mirror_q <= bank_d.ctrl[CTRL_MIRROR_BIT];
      res_xl_q     <= xl;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign irq_line_o           = res_irq_q;
  assign mirroring_vertical_o = res_mirror_q;
  assign region_o             = res_xl_q.region;
  assign phys_addr_o          = res_xl_q.phys_addr;
  assign access_enabled_o     = res_xl_q.access_enabled;

endmodule

`default_nettype wire
